// File: rtl/core/pff_pkg.sv
// Shared constants and types of the potential-field force unit.
package pff_pkg;

  localparam int FRAC_BITS     = 4;
  localparam int COORD_WIDTH   = 20;
  localparam int RAD_WIDTH     = 19;
  localparam int GAIN_WIDTH    = 16;
  localparam int FORCE_WIDTH   = 48;
  localparam longint REPULSE_FORCE = 64'd1000000000;

  typedef enum logic [1:0] {
    ZONE_INSIDE = 2'd0,
    ZONE_BAND   = 2'd1,
    ZONE_BEYOND = 2'd2
  } zone_t;

  function automatic int max2(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

// File: rtl/core/pff_sqrt.sv
// Pipelined integer square root, one root bit per stage, with a carried sideband.
module pff_sqrt #(
  parameter int RW = 44,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_vld,
  input  logic [RW-1:0] rad,
  input  logic [SW-1:0] in_side,
  output logic          out_vld,
  output logic [RW/2-1:0] root,
  output logic [SW-1:0] out_side
);
  localparam int N    = RW / 2;
  localparam int REMW = N + 2;

  logic            vld [N+1];
  logic [REMW-1:0] rm  [N+1];
  logic [N-1:0]    rt  [N+1];
  logic [RW-1:0]   rd  [N+1];
  logic [SW-1:0]   sd  [N+1];

  assign vld[0] = in_vld;
  assign rm[0]  = '0;
  assign rt[0]  = '0;
  assign rd[0]  = rad;
  assign sd[0]  = in_side;

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [REMW-1:0] cur;
    logic [REMW-1:0] trial;
    // remainder stays below 2^N before the last stage, so its top bits drop
    assign cur   = {rm[i][REMW-3:0], rd[i][RW-1 -: 2]};
    assign trial = {rt[i], 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (cur >= trial) begin
        rm[i+1] <= cur - trial;
        rt[i+1] <= {rt[i][N-2:0], 1'b1};
      end else begin
        rm[i+1] <= cur;
        rt[i+1] <= {rt[i][N-2:0], 1'b0};
      end
      rd[i+1] <= rd[i] << 2;
      sd[i+1] <= sd[i];
    end
  end

  assign out_vld  = vld[N];
  assign root     = rt[N];
  assign out_side = sd[N];

endmodule

// File: rtl/core/pff_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a carried sideband.
module pff_div #(
  parameter int NW  = 59,
  parameter int QW  = 38,
  parameter int DNW = 22,
  parameter int SW  = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_vld,
  input  logic [NW-1:0]  num,
  input  logic [DNW-1:0] den,
  input  logic [SW-1:0]  in_side,
  output logic           out_vld,
  output logic [QW-1:0]  quo,
  output logic [SW-1:0]  out_side
);
  // quotient is known to fit QW bits, so the numerator top is already below den
  localparam int TW = NW - QW;

  logic           vld [QW+1];
  logic [DNW-1:0] rm  [QW+1];
  logic [QW-1:0]  lo  [QW+1];
  logic [DNW-1:0] dn  [QW+1];
  logic [SW-1:0]  sd  [QW+1];

  assign vld[0] = in_vld;
  assign rm[0]  = {{(DNW-TW){1'b0}}, num[NW-1:QW]};
  assign lo[0]  = num[QW-1:0];
  assign dn[0]  = den;
  assign sd[0]  = in_side;

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DNW:0] cur;
    logic [DNW:0] diff;
    logic         ge;
    assign cur  = {rm[i], lo[i][QW-1]};
    assign diff = cur - {1'b0, dn[i]};
    assign ge   = cur >= {1'b0, dn[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      rm[i+1] <= ge ? diff[DNW-1:0] : cur[DNW-1:0];
      lo[i+1] <= {lo[i][QW-2:0], ge};
      dn[i+1] <= dn[i];
      sd[i+1] <= sd[i];
    end
  end

  assign out_vld  = vld[QW];
  assign quo      = lo[QW];
  assign out_side = sd[QW];

endmodule

// File: rtl/core/potential_field_force_unit.sv
// Top level of the potential-field force unit: attract / repulse force per query.
//
// One beat in on start, one result beat out on done, in order. The unit is fully
// pipelined: busy never rises, a new beat can be started in every cycle, and the
// receiver must take done the cycle it shows. MAGW, the force magnitude width, is
// max(16 + max(COORD_WIDTH + 2, 19), 30 + FRAC_BITS). The square root computes one
// root bit per stage and the two restoring dividers one quotient bit per stage.
// Distance is floored; forces are truncated toward zero and clamped to 48 bits.
module potential_field_force_unit #(
  parameter int FRAC_BITS   = pff_pkg::FRAC_BITS,
  parameter int COORD_WIDTH = pff_pkg::COORD_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [COORD_WIDTH-1:0]       agent_x,
  input  logic signed [COORD_WIDTH-1:0]       agent_y,
  input  logic signed [COORD_WIDTH-1:0]       target_x,
  input  logic signed [COORD_WIDTH-1:0]       target_y,
  input  logic                                attract_mode,
  input  logic [pff_pkg::RAD_WIDTH-1:0]       inner_radius,
  input  logic [pff_pkg::RAD_WIDTH-1:0]       band_spread,
  input  logic signed [pff_pkg::GAIN_WIDTH-1:0] field_gain,
  output logic                                done,
  output logic signed [pff_pkg::FORCE_WIDTH-1:0] force_x,
  output logic signed [pff_pkg::FORCE_WIDTH-1:0] force_y,
  output logic [1:0]                          zone
);
  localparam int RADW  = pff_pkg::RAD_WIDTH;
  localparam int GW    = pff_pkg::GAIN_WIDTH;
  localparam int FW    = pff_pkg::FORCE_WIDTH;
  localparam int DW    = COORD_WIDTH + 1;            // offset and its magnitude
  localparam int DISTW = DW + 1;                     // floored distance
  localparam int SQRW  = 2 * DISTW;                  // root radicand
  localparam int CMPW  = pff_pkg::max2(DISTW, RADW + 1);
  localparam int OPW   = pff_pkg::max2(DISTW, RADW);
  localparam int MAGW  = pff_pkg::max2(GW + OPW, 30 + FRAC_BITS);
  localparam int PW    = MAGW + DW;
  localparam int QEW   = pff_pkg::max2(MAGW, FW) + 1;
  localparam int SBW   = 1 + RADW + RADW + GW + 1 + 1 + 1 + DW + DW;

  localparam logic [MAGW-1:0] REP_MAG = MAGW'(pff_pkg::REPULSE_FORCE) << FRAC_BITS;
  localparam logic [QEW-1:0]  MAXP    = QEW'({1'b0, {(FW-1){1'b1}}});

  // fully pipelined, never holds off a start
  assign busy = 1'b0;

  // stage 1: offsets
  logic                   s1_vld;
  logic signed [DW-1:0]   s1_dx, s1_dy;
  logic                   s1_att;
  logic [RADW-1:0]        s1_r, s1_s;
  logic signed [GW-1:0]   s1_g;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= start;
    end
  end

  always_ff @(posedge clk) begin
    s1_dx  <= DW'(target_x) - DW'(agent_x);
    s1_dy  <= DW'(target_y) - DW'(agent_y);
    s1_att <= attract_mode;
    s1_r   <= inner_radius;
    s1_s   <= band_spread;
    s1_g   <= field_gain;
  end

  // stage 2: magnitudes and signs
  logic              s2_vld;
  logic [DW-1:0]     s2_mx, s2_my;
  logic              s2_nx, s2_ny;
  logic              s2_att;
  logic [RADW-1:0]   s2_r, s2_s;
  logic [GW-1:0]     s2_gm;
  logic              s2_gneg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    s2_mx   <= s1_dx[DW-1] ? DW'(-s1_dx) : DW'(s1_dx);
    s2_my   <= s1_dy[DW-1] ? DW'(-s1_dy) : DW'(s1_dy);
    s2_nx   <= s1_dx[DW-1];
    s2_ny   <= s1_dy[DW-1];
    s2_att  <= s1_att;
    s2_r    <= s1_r;
    s2_s    <= s1_s;
    s2_gm   <= s1_g[GW-1] ? GW'(-s1_g) : GW'(s1_g);
    s2_gneg <= s1_g[GW-1];
  end

  // stage 3: squares
  logic               s3_vld;
  logic [2*DW-1:0]    s3_sqx, s3_sqy;
  logic [SBW-1:0]     s3_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else begin
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    s3_sqx  <= s2_mx * s2_mx;
    s3_sqy  <= s2_my * s2_my;
    s3_side <= {s2_att, s2_r, s2_s, s2_gm, s2_gneg, s2_nx, s2_ny, s2_mx, s2_my};
  end

  // stage 4: squared distance
  logic               s4_vld;
  logic [2*DW:0]      s4_sum;
  logic [SBW-1:0]     s4_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else begin
      s4_vld <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    s4_sum  <= (2*DW+1)'(s3_sqx) + (2*DW+1)'(s3_sqy);
    s4_side <= s3_side;
  end

  // floored distance
  logic               rt_vld;
  logic [DISTW-1:0]   rt_d;
  logic [SBW-1:0]     rt_side;

  pff_sqrt #(
    .RW (SQRW),
    .SW (SBW)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (s4_vld),
    .rad      ({1'b0, s4_sum}),
    .in_side  (s4_side),
    .out_vld  (rt_vld),
    .root     (rt_d),
    .out_side (rt_side)
  );

  logic            rt_att, rt_gneg, rt_nx, rt_ny;
  logic [RADW-1:0] rt_r, rt_s;
  logic [GW-1:0]   rt_gm;
  logic [DW-1:0]   rt_mx, rt_my;

  assign {rt_att, rt_r, rt_s, rt_gm, rt_gneg, rt_nx, rt_ny, rt_mx, rt_my} = rt_side;

  // stage 5: zone, ramp operand, direction fixup for zero distance
  logic [CMPW-1:0]    dc, rc, rsc;
  pff_pkg::zone_t     zone_next;
  logic [CMPW-1:0]    op_next;
  logic               dzero;

  always_comb begin
    dc    = CMPW'(rt_d);
    rc    = CMPW'(rt_r);
    rsc   = CMPW'(rt_r) + CMPW'(rt_s);
    dzero = (rt_d == '0);
    if (dc < rc) begin
      zone_next = pff_pkg::ZONE_INSIDE;
    end else if (dc <= rsc) begin
      zone_next = pff_pkg::ZONE_BAND;
    end else begin
      zone_next = pff_pkg::ZONE_BEYOND;
    end
    op_next = '0;
    case (zone_next)
      pff_pkg::ZONE_BAND: begin
        op_next = rt_att ? (dc - rc) : (rsc - dc);
      end
      pff_pkg::ZONE_BEYOND: begin
        op_next = rt_att ? CMPW'(rt_s) : '0;
      end
      default: begin
        op_next = '0;
      end
    endcase
  end

  logic               s5_vld;
  pff_pkg::zone_t     s5_zone;
  logic [OPW-1:0]     s5_op;
  logic               s5_rep;
  logic [GW-1:0]      s5_gm;
  logic               s5_negx, s5_negy;
  logic [DW-1:0]      s5_mx, s5_my;
  logic [DISTW-1:0]   s5_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld <= 1'b0;
    end else begin
      s5_vld <= rt_vld;
    end
  end

  always_ff @(posedge clk) begin
    // repulse inside the radius: fixed push away from the target
    s5_zone <= zone_next;
    s5_op   <= OPW'(op_next);
    s5_rep  <= !rt_att && (zone_next == pff_pkg::ZONE_INSIDE);
    s5_gm   <= rt_gm;
    s5_negx <= ((!rt_att && (zone_next == pff_pkg::ZONE_INSIDE)) || rt_gneg)
               ^ (rt_nx && !dzero);
    s5_negy <= ((!rt_att && (zone_next == pff_pkg::ZONE_INSIDE)) || rt_gneg)
               ^ (rt_ny && !dzero);
    // zero distance takes the +x direction, negated by repulse or a negative gain
    s5_mx   <= dzero ? DW'(1) : rt_mx;
    s5_my   <= dzero ? '0 : rt_my;
    s5_den  <= dzero ? DISTW'(1) : rt_d;
  end

  // stage 6: magnitude
  logic [GW+OPW-1:0]  gprod;
  assign gprod = s5_gm * s5_op;

  logic               s6_vld;
  logic [MAGW-1:0]    s6_mag;
  pff_pkg::zone_t     s6_zone;
  logic               s6_negx, s6_negy;
  logic [DW-1:0]      s6_mx, s6_my;
  logic [DISTW-1:0]   s6_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_vld <= 1'b0;
    end else begin
      s6_vld <= s5_vld;
    end
  end

  always_ff @(posedge clk) begin
    s6_mag  <= s5_rep ? REP_MAG : MAGW'(gprod);
    s6_zone <= s5_zone;
    s6_negx <= s5_negx;
    s6_negy <= s5_negy;
    s6_mx   <= s5_mx;
    s6_my   <= s5_my;
    s6_den  <= s5_den;
  end

  // stage 7: scaled numerators
  logic               s7_vld;
  logic [PW-1:0]      s7_px, s7_py;
  pff_pkg::zone_t     s7_zone;
  logic               s7_negx, s7_negy;
  logic [DISTW-1:0]   s7_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_vld <= 1'b0;
    end else begin
      s7_vld <= s6_vld;
    end
  end

  always_ff @(posedge clk) begin
    s7_px   <= s6_mag * s6_mx;
    s7_py   <= s6_mag * s6_my;
    s7_zone <= s6_zone;
    s7_negx <= s6_negx;
    s7_negy <= s6_negy;
    s7_den  <= s6_den;
  end

  // direction divide: |m| * |dx| / d, quotient never exceeds |m|
  logic              dvx_vld, dvy_vld;
  logic [MAGW-1:0]   qx, qy;
  logic [2:0]        dvx_side;
  logic              dvy_side;

  pff_div #(
    .NW  (PW),
    .QW  (MAGW),
    .DNW (DISTW),
    .SW  (3)
  ) u_div_x (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (s7_vld),
    .num      (s7_px),
    .den      (s7_den),
    .in_side  ({s7_zone, s7_negx}),
    .out_vld  (dvx_vld),
    .quo      (qx),
    .out_side (dvx_side)
  );

  pff_div #(
    .NW  (PW),
    .QW  (MAGW),
    .DNW (DISTW),
    .SW  (1)
  ) u_div_y (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (s7_vld),
    .num      (s7_py),
    .den      (s7_den),
    .in_side  (s7_negy),
    .out_vld  (dvy_vld),
    .quo      (qy),
    .out_side (dvy_side)
  );

  // sign and clamp to the 48-bit force range
  logic [QEW-1:0] qxe, qye, limx, limy;

  always_comb begin
    qxe = QEW'(qx);
    qye = QEW'(qy);
    if (dvx_side[0]) begin
      limx = (qxe > MAXP + QEW'(1)) ? MAXP + QEW'(1) : qxe;
    end else begin
      limx = (qxe > MAXP) ? MAXP : qxe;
    end
    if (dvy_side) begin
      limy = (qye > MAXP + QEW'(1)) ? MAXP + QEW'(1) : qye;
    end else begin
      limy = (qye > MAXP) ? MAXP : qye;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dvx_vld && dvy_vld;
    end
  end

  always_ff @(posedge clk) begin
    force_x <= dvx_side[0] ? -FW'(limx) : FW'(limx);
    force_y <= dvy_side ? -FW'(limy) : FW'(limy);
    zone    <= dvx_side[2:1];
  end

endmodule

// File: rtl/core/pff_checker.sv
// Port-level checks for the potential-field force unit, bound to the top level.
module pff_checker #(
  parameter int FRAC_BITS   = pff_pkg::FRAC_BITS,
  parameter int COORD_WIDTH = pff_pkg::COORD_WIDTH
) (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   start,
  input logic                                   busy,
  input logic signed [COORD_WIDTH-1:0]          agent_x,
  input logic signed [COORD_WIDTH-1:0]          agent_y,
  input logic signed [COORD_WIDTH-1:0]          target_x,
  input logic signed [COORD_WIDTH-1:0]          target_y,
  input logic                                   attract_mode,
  input logic [pff_pkg::RAD_WIDTH-1:0]          inner_radius,
  input logic [pff_pkg::RAD_WIDTH-1:0]          band_spread,
  input logic signed [pff_pkg::GAIN_WIDTH-1:0]  field_gain,
  input logic                                   done,
  input logic signed [pff_pkg::FORCE_WIDTH-1:0] force_x,
  input logic signed [pff_pkg::FORCE_WIDTH-1:0] force_y,
  input logic [1:0]                             zone
);

  // pipeline depth: input regs, root stages, zone/magnitude/product, quotient stages, output
  localparam int MAGW = pff_pkg::max2(
    pff_pkg::GAIN_WIDTH + pff_pkg::max2(COORD_WIDTH + 2, pff_pkg::RAD_WIDTH), 30 + FRAC_BITS);
  localparam int LAT  = 4 + (COORD_WIDTH + 2) + 3 + MAGW + 1;

  // pipeline drains on reset
  a_reset_clears_done: assert property (@(posedge clk) rst |=> !done)
    else $error("done high right after reset");

  // pipeline never refuses a beat
  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  // result beat carries known values and a legal zone code
  a_zone_legal: assert property (@(posedge clk) disable iff (rst)
    done |-> (!$isunknown({force_x, force_y, zone}) &&
              (zone == pff_pkg::ZONE_INSIDE || zone == pff_pkg::ZONE_BAND ||
               zone == pff_pkg::ZONE_BEYOND)))
    else $error("illegal zone code on result beat");

  // accepted beat carries known operands
  a_inputs_known: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> !$isunknown({agent_x, agent_y, target_x, target_y, attract_mode,
                                      inner_radius, band_spread, field_gain}))
    else $error("unknown operand on accepted beat");

  // fixed latency from accept to result
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("result beat missing at fixed latency");

endmodule

bind potential_field_force_unit pff_checker #(
  .FRAC_BITS   (FRAC_BITS),
  .COORD_WIDTH (COORD_WIDTH)
) u_pff_checker (.*);
